### rtl/box_blur_3x3_rgb_core_defines.svh
// Assertion macros used by the box blur port checker.
`ifndef BOX_BLUR_3X3_RGB_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_CORE_DEFINES_SVH

// Checked only while reset is released.
`define BB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BB3_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bb3_pkg.sv
// Types, constants and the rounding divider of the 3x3 box blur.
package bb3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int POS_W      = $clog2(MAX_WIDTH);
  localparam int SIZE_W     = 11;
  localparam int JOB_DEPTH  = 4;
  localparam int JOB_PTR_W  = $clog2(JOB_DEPTH);

  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [3:0] CNT_FULL   = 4'd9;
  localparam logic [3:0] CNT_EDGE   = 4'd6;
  localparam logic [3:0] CNT_CORNER = 4'd4;

  // Reciprocals of 2*n scaled by 2**17, rounded up; exact for 2*sum+n below 32768.
  localparam int RECIP_SHIFT = 17;
  localparam logic [14:0] RECIP_FULL   = 15'd7282;
  localparam logic [14:0] RECIP_EDGE   = 15'd10923;
  localparam logic [14:0] RECIP_CORNER = 15'd16384;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // Index 0 is row r-2, index 1 row r-1, index 2 row r.
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    col_t             w1;
    col_t             w0;
    col_t             cur;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [3:0]       mask;
    logic             c_ge2;
    logic             r_ge2;
  } job_t;

  function automatic logic [7:0] round_mean(input logic [11:0] sum, input logic [3:0] n);
    logic [12:0] t;
    logic [14:0] m;
    logic [27:0] p;
    t = {sum, 1'b0} + {9'd0, n};
    case (n)
      CNT_FULL: m = RECIP_FULL;
      CNT_EDGE: m = RECIP_EDGE;
      default:  m = RECIP_CORNER;
    endcase
    p = {15'd0, t} * {13'd0, m};
    return p[RECIP_SHIFT +: 8];
  endfunction

endpackage

### rtl/box_blur_3x3_rgb_core.sv
// Top level of the streaming 3x3 RGB box blur.
//
// Channel | Direction | Content
// in_     | slave     | tdata: red, green, blue (raster order pixel)
// out_    | master    | tdata: red, green, blue, row, column; tuser: end of burst;
//         |           | tlast: end of image
// cfg_    | slave     | index 0 image width, index 1 image height
//
// One pixel per cycle is accepted while in_tready is high. Both line stores share one
// 1024 x 48 memory, read at acceptance and written back in the following cycle.
// Below the first row, a last-column pixel causes two results, a last-row pixel past
// the first column two, and the bottom-right pixel four. A four-deep job queue feeds
// the one-result-per-cycle emitter, which out_tready may hold; the last row can fill
// the queue. in_tready drops when the queue plus the pixel in flight would fill it.
// Reset or a write to index 0 or 1 restarts the image.
module box_blur_3x3_rgb_core import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // red, green, blue
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [47:0]       out_tdata,  // red, green, blue, row, column, zero fill
  output logic              out_tuser,  // end_of_burst
  output logic              out_tlast,  // end_of_image
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  logic [SIZE_W-1:0] width_r, height_r, w_eff, h_eff;
  logic [POS_W-1:0]  row_r, col_r;
  logic              in_acc, cfg_acc, restart;
  logic              last_col, last_row;

  logic [47:0]       mem [MAX_WIDTH];
  logic [47:0]       rd_r;

  logic              s1_valid_r;
  pix_t              s1_pix_r;
  logic [POS_W-1:0]  s1_row_r, s1_col_r;
  logic              s1_lc_r, s1_lr_r;
  col_t              w0_r, w1_r, cur;
  logic [3:0]        s1_mask;

  job_t              job_q [JOB_DEPTH];
  logic [JOB_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JOB_PTR_W:0]   cnt_r;
  logic              push, pop, issue, advance;
  logic [3:0]        done_r, pend, pick;
  logic              is_last;
  job_t              head;

  logic              e0_valid_r, e0_eob_r, e0_eoi_r;
  logic [11:0]       e0_sum_r [3];
  logic [3:0]        e0_n_r;
  logic [POS_W-1:0]  e0_row_r, e0_col_r;

  logic              use_w1, use_row0;
  logic [11:0]       sum_nxt [3];
  logic [3:0]        n_nxt;

  logic              out_valid_r, out_eob_r, out_eoi_r;
  pix_t              out_pix_r;
  logic [POS_W-1:0]  out_row_r, out_col_r;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid;
  assign restart   = cfg_acc && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  assign w_eff = (width_r < SIZE_W'(2)) ? SIZE_W'(2) :
                 (width_r > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r < SIZE_W'(2)) ? SIZE_W'(2) :
                 (height_r > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_r;
  assign last_col = ({1'b0, col_r} == w_eff - SIZE_W'(1));
  assign last_row = ({1'b0, row_r} == h_eff - SIZE_W'(1));

  assign in_tready = (cnt_r + {{JOB_PTR_W{1'b0}}, s1_valid_r}) < (JOB_PTR_W+1)'(JOB_DEPTH);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SIZE_W'(2);
      height_r <= SIZE_W'(2);
      row_r    <= '0;
      col_r    <= '0;
    end else if (restart) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end else begin
        height_r <= cfg_data;
      end
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : row_r + POS_W'(1);
      end else begin
        col_r <= col_r + POS_W'(1);
      end
    end
  end

  // Entry holds {row r-1, row r-2} for its column; consecutive pixels of one image never share one.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= mem[col_r];
    end
    if (s1_valid_r) begin
      mem[s1_col_r] <= {s1_pix_r, rd_r[47:24]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_acc;
    end
    if (in_acc) begin
      s1_pix_r <= in_tdata;
      s1_row_r <= row_r;
      s1_col_r <= col_r;
      s1_lc_r  <= last_col;
      s1_lr_r  <= last_row;
    end
  end

  always_comb begin
    cur[0] = rd_r[23:0];
    cur[1] = rd_r[47:24];
    cur[2] = s1_pix_r;
    s1_mask[0] = (s1_row_r != '0) && (s1_col_r != '0);
    s1_mask[1] = (s1_row_r != '0) && s1_lc_r;
    s1_mask[2] = s1_lr_r && (s1_col_r != '0);
    s1_mask[3] = s1_lr_r && s1_lc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      w0_r <= '0;
      w1_r <= '0;
    end else if (s1_valid_r) begin
      w1_r <= w0_r;
      w0_r <= cur;
    end
  end

  assign push = s1_valid_r && (s1_mask != 4'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      job_q[wr_ptr_r] <= '{w1: w1_r, w0: w0_r, cur: cur, row: s1_row_r, col: s1_col_r,
                            mask: s1_mask, c_ge2: (s1_col_r > POS_W'(1)),
                            r_ge2: (s1_row_r > POS_W'(1))};
    end
  end

  assign advance = !out_valid_r || out_tready;
  assign issue   = advance && (cnt_r != '0);
  assign head    = job_q[rd_ptr_r];
  assign pend    = head.mask & ~done_r;
  assign pick    = pend & (~pend + 4'd1);
  assign is_last = (pend & ~pick) == 4'd0;
  assign pop     = issue && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      done_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + JOB_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + JOB_PTR_W'(1);
        done_r   <= '0;
      end else if (issue) begin
        done_r <= done_r | pick;
      end
      cnt_r <= cnt_r + {{JOB_PTR_W{1'b0}}, push} - {{JOB_PTR_W{1'b0}}, pop};
    end
  end

  // Upper results use rows r-2..r, lower rows r-1..r; row r-2 and column c-2 only if present.
  always_comb begin
    use_w1   = (pick[0] || pick[2]) && head.c_ge2;
    use_row0 = (pick[0] || pick[1]) && head.r_ge2;
    if (use_w1 && use_row0) begin
      n_nxt = CNT_FULL;
    end else if (use_w1 || use_row0) begin
      n_nxt = CNT_EDGE;
    end else begin
      n_nxt = CNT_CORNER;
    end
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
    end
    for (int j = 0; j < 3; j++) begin
      if (j != 0 || use_row0) begin
        sum_nxt[0] = sum_nxt[0] + {4'd0, head.w0[j].red} + {4'd0, head.cur[j].red} +
                     (use_w1 ? {4'd0, head.w1[j].red} : 12'd0);
        sum_nxt[1] = sum_nxt[1] + {4'd0, head.w0[j].green} + {4'd0, head.cur[j].green} +
                     (use_w1 ? {4'd0, head.w1[j].green} : 12'd0);
        sum_nxt[2] = sum_nxt[2] + {4'd0, head.w0[j].blue} + {4'd0, head.cur[j].blue} +
                     (use_w1 ? {4'd0, head.w1[j].blue} : 12'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      e0_valid_r  <= issue;
      out_valid_r <= e0_valid_r;
    end
    if (advance) begin
      e0_sum_r <= sum_nxt;
      e0_n_r   <= n_nxt;
      e0_row_r <= (pick[0] || pick[1]) ? head.row - POS_W'(1) : head.row;
      e0_col_r <= (pick[0] || pick[2]) ? head.col - POS_W'(1) : head.col;
      e0_eob_r <= is_last;
      e0_eoi_r <= pick[3];
      out_pix_r.red   <= round_mean(e0_sum_r[0], e0_n_r);
      out_pix_r.green <= round_mean(e0_sum_r[1], e0_n_r);
      out_pix_r.blue  <= round_mean(e0_sum_r[2], e0_n_r);
      out_row_r <= e0_row_r;
      out_col_r <= e0_col_r;
      out_eob_r <= e0_eob_r;
      out_eoi_r <= e0_eoi_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_col_r, out_row_r, out_pix_r};
  assign out_tuser  = out_eob_r;
  assign out_tlast  = out_eoi_r;

endmodule

### rtl/bb3_checker.sv
// Port-level checks of the box blur core and their binding.
`include "box_blur_3x3_rgb_core_defines.svh"
module bb3_port_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [47:0]       out_tdata,
  input logic              out_tuser,
  input logic              out_tlast
);

  `BB3_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")
  `BB3_ASSERT(a_eoi_eob, out_tvalid && out_tlast |-> out_tuser, "end of image without end of burst")
  `BB3_ASSERT(a_eoi_pos, out_tvalid && out_tlast |-> out_tdata[33:24] != 10'd0 && out_tdata[43:34] != 10'd0, "end of image at top or left border")
  `BB3_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid, "result valid right after reset")

endmodule

bind box_blur_3x3_rgb_core bb3_port_checker u_bb3_checker (.*);

### dv/bb3_checker.sv
// Checker for the 3x3 box blur: predicts blurred pixels and compares each result transaction.
module bb3_checker import bb3_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [23:0]       in_tdata,
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [47:0]       out_tdata,
  input  logic              out_tuser,
  input  logic              out_tlast,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] row;
    logic [9:0] column;
    logic       end_of_burst;
    logic       end_of_image;
  } blurred_t;

  blurred_t blurred_q[$];
  pix_t     older_row[MAX_WIDTH];
  pix_t     newer_row[MAX_WIDTH];
  pix_t     win1[3];
  pix_t     win0[3];
  pix_t     cur[3];
  int       next_row;
  int       next_col;
  int       image_w;
  int       image_h;
  int       mismatches;

  assign pending    = blurred_q.size();
  assign fail_count = mismatches;

  function automatic int clamp_size(int v, int hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] rounded_mean(int sum, int n);
    return 8'((2 * sum + n) / (2 * n));
  endfunction

  // Averages columns w0 and cur (plus w1 when asked) over rows first..2.
  task automatic push_blurred(bit use_w1, int first, int row, int column, bit eoi);
    int       sr, sg, sb, n;
    blurred_t e;
    sr = 0; sg = 0; sb = 0;
    n = (use_w1 ? 3 : 2) * (3 - first);
    for (int j = first; j < 3; j++) begin
      if (use_w1) begin
        sr += win1[j].red; sg += win1[j].green; sb += win1[j].blue;
      end
      sr += win0[j].red + cur[j].red;
      sg += win0[j].green + cur[j].green;
      sb += win0[j].blue + cur[j].blue;
    end
    e.red          = rounded_mean(sr, n);
    e.green        = rounded_mean(sg, n);
    e.blue         = rounded_mean(sb, n);
    e.row          = 10'(row);
    e.column       = 10'(column);
    e.end_of_burst = 1'b0;
    e.end_of_image = eoi;
    blurred_q.push_back(e);
  endtask

  task automatic blur_pixel(pix_t px);
    int w, h, r, c, start;
    bit last_col, last_row;
    w = clamp_size(image_w, MAX_WIDTH);
    h = clamp_size(image_h, MAX_HEIGHT);
    r = next_row;
    c = next_col;
    if (r >= h || c >= w) begin
      r = 0; c = 0;
    end
    last_col = (c == w - 1);
    last_row = (r == h - 1);
    start = blurred_q.size();
    cur[0] = older_row[c];
    cur[1] = newer_row[c];
    cur[2] = px;
    if (r >= 1 && c >= 1) push_blurred(c >= 2, (r >= 2) ? 0 : 1, r - 1, c - 1, 1'b0);
    if (r >= 1 && last_col) push_blurred(1'b0, (r >= 2) ? 0 : 1, r - 1, c, 1'b0);
    if (last_row && c >= 1) push_blurred(c >= 2, 1, r, c - 1, 1'b0);
    if (last_row && last_col) push_blurred(1'b0, 1, r, c, 1'b1);
    if (blurred_q.size() > start) blurred_q[blurred_q.size() - 1].end_of_burst = 1'b1;
    older_row[c] = newer_row[c];
    newer_row[c] = px;
    win1 = win0;
    win0 = cur;
    if (last_col) begin
      next_col = 0;
      next_row = last_row ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endtask

  task automatic restart_image();
    next_row = 0;
    next_col = 0;
    for (int j = 0; j < 3; j++) begin
      win0[j] = '0;
      win1[j] = '0;
    end
  endtask

  always @(posedge clk) begin
    blurred_t e;
    pix_t     px;
    if (!rst_n) begin
      blurred_q.delete();
      for (int i = 0; i < MAX_WIDTH; i++) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
      image_w = 2;
      image_h = 2;
      mismatches = 0;
      restart_image();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_IMAGE_WIDTH) begin
          image_w = int'(cfg_data);
          restart_image();
        end else if (cfg_index == REG_IMAGE_HEIGHT) begin
          image_h = int'(cfg_data);
          restart_image();
        end
      end
      if (in_tvalid && in_tready) begin
        px.red   = in_tdata[7:0];
        px.green = in_tdata[15:8];
        px.blue  = in_tdata[23:16];
        blur_pixel(px);
      end
      if (out_tvalid && out_tready) begin
        if (blurred_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: unexpected result transaction tdata=%h", out_tdata);
        end else begin
          e = blurred_q.pop_front();
          if (out_tdata[7:0] !== e.red || out_tdata[15:8] !== e.green ||
              out_tdata[23:16] !== e.blue || out_tdata[33:24] !== e.row ||
              out_tdata[43:34] !== e.column || out_tdata[47:44] !== 4'd0 ||
              out_tuser !== e.end_of_burst || out_tlast !== e.end_of_image) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"ERROR: pixel (%0d,%0d) expected rgb=%h/%h/%h eob=%b eoi=%b, ",
                        "got row=%0d col=%0d rgb=%h/%h/%h pad=%h eob=%b eoi=%b"},
                       e.row, e.column, e.red, e.green, e.blue, e.end_of_burst,
                       e.end_of_image, out_tdata[33:24], out_tdata[43:34],
                       out_tdata[7:0], out_tdata[15:8], out_tdata[23:16],
                       out_tdata[47:44], out_tuser, out_tlast);
          end
        end
      end
    end
  end
endmodule

### dv/tb_top.sv
// Top of the box blur testbench: clock, reset, stimulus and the final verdict.
module tb_top;
  import bb3_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_SPARE_2 = 2'd2;
  localparam logic [1:0] REG_SPARE_3 = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE     = 12;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [23:0]       in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [47:0]       out_tdata;
  logic              out_tuser;
  logic              out_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [SIZE_W-1:0] cfg_data = '0;
  int                fail_count;
  int                pending;
  int                idle_cycles = 0;
  int                stall_left = 0;
  int                pixels_sent = 0;
  bit                busy_phase = 1'b1;

  always #1 clk = ~clk;

  box_blur_3x3_rgb_core i_dut (.*);
  bb3_checker i_checker (.*);

  // Sink backpressure: phases without stalls alternate with phases of mostly short stalls.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) busy_phase <= ~busy_phase;
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if (busy_phase && $urandom_range(0, 3) == 0)
        stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int source_gap();
    if (!busy_phase || $urandom_range(0, 2) != 0) return 0;
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 25);
  endfunction

  function automatic logic [7:0] channel_value();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
    int gap;
    gap = source_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {blue, green, red};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(int count);
    for (int i = 0; i < count; i++) send_pixel(channel_value(), channel_value(), channel_value());
  endtask

  // Lets every expected result drain, plus the pipeline depth for pixels that cause none.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [SIZE_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_size(int w, int h);
    write_reg(REG_IMAGE_WIDTH, SIZE_W'(w));
    write_reg(REG_IMAGE_HEIGHT, SIZE_W'(h));
  endtask

  initial begin
    int w, h, count;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Smallest image at reset size, with black and white extremes.
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'hFF);
    send_pixel(8'h00, 8'hFF, 8'h00);
    set_size(3, 3);
    for (int i = 0; i < 9; i++) send_pixel(8'(i * 37), 8'(255 - i * 29), (i % 2) ? 8'hFF : 8'h01);
    // Sizes below the minimum clamp to two.
    set_size(1, 0);
    send_random_pixels(4);
    // A mid-image write to an unused index must not restart the image.
    set_size(5, 4);
    send_random_pixels(7);
    write_reg(REG_SPARE_2, 11'h7FF);
    send_random_pixels(13);
    write_reg(REG_SPARE_3, 11'h555);
    // Oversize width clamps to the maximum; a tall narrow image is sent in part.
    set_size(2047, 2);
    send_random_pixels(24);
    set_size(2, 1024);
    send_random_pixels(40);

    while (pixels_sent < 370) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(2, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      count = (w < 2 ? 2 : w) * (h < 2 ? 2 : h);
      if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count);
      else if ($urandom_range(0, 4) == 0) count = 2 * count;
      if (count > 370 - pixels_sent) count = 370 - pixels_sent;
      set_size(w, h);
      send_random_pixels(count);
      if ($urandom_range(0, 3) == 0) drain();
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/bb3_pkg.sv
rtl/box_blur_3x3_rgb_core.sv
rtl/bb3_checker.sv
dv/bb3_checker.sv
dv/tb_top.sv
